/* hdl/assert_macros.svh */
// assertion helpers, sampled on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// condition must never be seen
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hdl/mbp_pkg.sv */
package mbp_pkg;

  localparam int SYSEX_DEPTH_DEFAULT = 32;
  localparam int MAX_RESULTS = 32;
  localparam int RUN_IW = $clog2(MAX_RESULTS);

  typedef enum logic [3:0] {
    KIND_NONE     = 4'd0,
    KIND_NOTEON   = 4'd1,
    KIND_NOTEOFF  = 4'd2,
    KIND_CC       = 4'd3,
    KIND_POLYAT   = 4'd4,
    KIND_BEND     = 4'd5,
    KIND_CHANAT   = 4'd6,
    KIND_PROGCHG  = 4'd7,
    KIND_REALTIME = 4'd8,
    KIND_SYSEX    = 4'd9
  } kind_t;

  // status bytes
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_COMMON_LAST = 8'hF6;
  localparam logic [7:0] ST_RT_FIRST    = 8'hF8;
  localparam logic [7:0] ST_RT_LAST     = 8'hFC;

  // upper nibble of a status byte
  localparam logic [3:0] HI_NOTEOFF = 4'h8;
  localparam logic [3:0] HI_NOTEON  = 4'h9;
  localparam logic [3:0] HI_POLYAT  = 4'hA;
  localparam logic [3:0] HI_CC      = 4'hB;
  localparam logic [3:0] HI_PROGCHG = 4'hC;
  localparam logic [3:0] HI_CHANAT  = 4'hD;
  localparam logic [3:0] HI_BEND    = 4'hE;
  localparam logic [3:0] HI_SYSTEM  = 4'hF;

  // controller numbers
  localparam logic [6:0] CTL_RESET     = 7'd127;
  localparam logic [6:0] CTL_FINE_LO   = 7'd32;
  localparam logic [6:0] CTL_FINE_HI   = 7'd63;
  localparam logic [6:0] CTL_FINE_STEP = 7'd32;

  typedef struct packed {
    logic              in_en;    // byte channel may accept
    logic              rd;       // read sysex store into read register
    logic [RUN_IW-1:0] rd_idx;
    logic              emit_sx;  // load one sysex result from read register
    logic              sx_last;
    logic              sx_ov;
  } cmd_t;

  typedef struct packed {
    logic              out_free; // output register empty or draining
    logic              sx_end;   // offered byte closes an open sysex
    logic [RUN_IW-1:0] run_len_m1;
    logic              run_ov;
  } status_t;

endpackage

/* hdl/mbp_in_if.sv */
interface mbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

/* hdl/mbp_out_if.sv */
interface mbp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] status_byte;
  logic [6:0] first_data;
  logic [6:0] second_data;
  logic [7:0] sysex_byte;
  logic       last;
  logic       overflow;

  modport source (output valid, output kind, output status_byte, output first_data,
                  output second_data, output sysex_byte, output last, output overflow,
                  input ready);
  modport sink (input valid, input kind, input status_byte, input first_data,
                input second_data, input sysex_byte, input last, input overflow,
                output ready);
endinterface

/* hdl/mbp_ctrl.sv */
module mbp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  mbp_pkg::status_t status,
  output mbp_pkg::cmd_t    cmd
);
  import mbp_pkg::*;

  typedef enum logic [1:0] {
    S_IN,
    S_LOAD,
    S_RUN
  } state_t;

  state_t            state;
  logic [RUN_IW-1:0] idx;
  logic [RUN_IW-1:0] len_m1;
  logic              run_ov;
  logic              run_done;

  assign run_done = (idx == len_m1);

  always_comb begin
    cmd = '0;
    cmd.sx_last = run_done;
    cmd.sx_ov   = run_ov;
    unique case (state)
      S_IN: cmd.in_en = status.out_free;
      S_LOAD: begin
        cmd.rd     = 1'b1;
        cmd.rd_idx = idx;
      end
      S_RUN: begin
        cmd.emit_sx = status.out_free;
        cmd.rd      = status.out_free && !run_done;
        cmd.rd_idx  = idx + RUN_IW'(1);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IN;
      idx    <= '0;
      len_m1 <= '0;
      run_ov <= 1'b0;
    end else begin
      unique case (state)
        S_IN: begin
          if (status.sx_end && status.out_free) begin
            idx    <= '0;
            len_m1 <= status.run_len_m1;
            run_ov <= status.run_ov;
            state  <= S_LOAD;
          end
        end
        S_LOAD: state <= S_RUN;
        S_RUN: begin
          if (status.out_free) begin
            if (run_done) begin
              state <= S_IN;
            end else begin
              idx <= idx + RUN_IW'(1);
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

endmodule

/* hdl/mbp_datapath.sv */
module mbp_datapath #(
  parameter int SYSEX_DEPTH = mbp_pkg::SYSEX_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  mbp_in_if.sink           byte_in,
  mbp_out_if.source        msg_out,
  input  mbp_pkg::cmd_t    cmd,
  output mbp_pkg::status_t status
);
  import mbp_pkg::*;

  localparam int AW = $clog2(SYSEX_DEPTH);
  localparam int CW = $clog2(SYSEX_DEPTH + 1);

  // parser state
  logic [7:0]    rs;
  logic [6:0]    prev_ctl;
  logic [7:0]    head;
  logic [6:0]    held;
  logic [CW-1:0] cnt;
  logic          ovf;

  logic [7:0]    rs_next;
  logic [6:0]    prev_ctl_next;
  logic [7:0]    head_next;
  logic [6:0]    held_next;
  logic [CW-1:0] cnt_next;
  logic          ovf_next;

  logic [7:0]    mem [SYSEX_DEPTH];
  logic [7:0]    rd_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic          acc;
  logic [7:0]    b;
  logic [3:0]    hi;
  logic          sx_open;
  logic          sx_full;
  logic [CW-1:0] n_m1;
  logic          n_sat;
  logic          fine_drop;

  logic          emit;
  kind_t         e_kind;
  logic [7:0]    e_st;
  logic [6:0]    e_d1;
  logic [6:0]    e_d2;

  assign b       = byte_in.in_byte;
  assign hi      = rs[7:4];
  assign acc     = byte_in.valid && cmd.in_en;
  assign sx_open = (head == ST_SYSEX_START);
  assign sx_full = (cnt == CW'(SYSEX_DEPTH));

  assign byte_in.ready = cmd.in_en;

  // run length minus one, counting the closing byte if the store has room, capped at the result limit
  assign n_m1  = sx_full ? cnt - CW'(1) : cnt;
  assign n_sat = (int'(n_m1) > MAX_RESULTS - 1);

  assign status.out_free   = !msg_out.valid || msg_out.ready;
  assign status.sx_end     = byte_in.valid && (b == ST_SYSEX_END) && sx_open;
  assign status.run_len_m1 = n_sat ? RUN_IW'(MAX_RESULTS - 1) : RUN_IW'(n_m1);
  assign status.run_ov     = ovf || sx_full || n_sat;

  assign fine_drop = (held >= CTL_FINE_LO) && (held <= CTL_FINE_HI) &&
                     (prev_ctl == held - CTL_FINE_STEP);

  always_comb begin
    rs_next       = rs;
    prev_ctl_next = prev_ctl;
    head_next     = head;
    held_next     = held;
    cnt_next      = cnt;
    ovf_next      = ovf;
    wr_en         = 1'b0;
    wr_addr       = cnt[AW-1:0];
    emit          = 1'b0;
    e_kind        = KIND_NONE;
    e_st          = rs;
    e_d1          = held;
    e_d2          = b[6:0];
    if (b[7]) begin
      if (b[7:4] != HI_SYSTEM) begin
        rs_next   = b;
        head_next = b;
        cnt_next  = CW'(1);
        ovf_next  = 1'b0;
      end else if (b >= ST_RT_FIRST && b <= ST_RT_LAST) begin
        emit   = 1'b1;
        e_kind = KIND_REALTIME;
        e_st   = b;
        e_d1   = '0;
        e_d2   = '0;
      end else if (b == ST_SYSEX_START) begin
        rs_next   = '0;
        head_next = ST_SYSEX_START;
        wr_en     = 1'b1;
        wr_addr   = '0;
        cnt_next  = CW'(1);
        ovf_next  = 1'b0;
      end else if (b == ST_SYSEX_END) begin
        rs_next   = '0;
        head_next = '0;
        wr_en     = sx_open && !sx_full;
        cnt_next  = '0;
        ovf_next  = 1'b0;
      end else if (b <= ST_COMMON_LAST) begin
        rs_next   = '0;
        head_next = b;
        cnt_next  = '0;
        ovf_next  = 1'b0;
      end
    end else if (sx_open) begin
      if (!sx_full) begin
        wr_en    = 1'b1;
        cnt_next = cnt + CW'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end else if (cnt == CW'(1) && rs[7]) begin
      if (hi == HI_CHANAT || hi == HI_PROGCHG) begin
        emit   = 1'b1;
        e_kind = (hi == HI_CHANAT) ? KIND_CHANAT : KIND_PROGCHG;
        e_d1   = b[6:0];
        e_d2   = '0;
      end else begin
        held_next = b[6:0];
        cnt_next  = CW'(2);
      end
    end else if (cnt == CW'(2) && rs[7]) begin
      cnt_next = CW'(1);
      case (hi)
        HI_NOTEON: begin
          emit = 1'b1;
          if (b[6:0] != 7'd0) begin
            e_kind = KIND_NOTEON;
          end else begin
            e_kind = KIND_NOTEOFF;
            e_d2   = '0;
          end
        end
        HI_NOTEOFF: begin
          emit   = 1'b1;
          e_kind = KIND_NOTEOFF;
          e_d2   = '0;
        end
        HI_CC: begin
          prev_ctl_next = held;
          emit          = !fine_drop;
          e_kind        = KIND_CC;
        end
        HI_POLYAT: begin
          emit   = 1'b1;
          e_kind = KIND_POLYAT;
        end
        HI_BEND: begin
          emit   = 1'b1;
          e_kind = KIND_BEND;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rs       <= '0;
      prev_ctl <= CTL_RESET;
      head     <= '0;
      held     <= '0;
      cnt      <= '0;
      ovf      <= 1'b0;
    end else if (acc) begin
      rs       <= rs_next;
      prev_ctl <= prev_ctl_next;
      head     <= head_next;
      held     <= held_next;
      cnt      <= cnt_next;
      ovf      <= ovf_next;
    end
  end

  // sysex store
  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      mem[wr_addr] <= b;
    end
    if (cmd.rd) begin
      rd_q <= mem[AW'(cmd.rd_idx)];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_out.valid <= 1'b0;
    end else if ((acc && emit) || cmd.emit_sx) begin
      msg_out.valid <= 1'b1;
    end else if (msg_out.ready) begin
      msg_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sx) begin
      msg_out.kind        <= KIND_SYSEX;
      msg_out.status_byte <= ST_SYSEX_START;
      msg_out.first_data  <= '0;
      msg_out.second_data <= '0;
      msg_out.sysex_byte  <= rd_q;
      msg_out.last        <= cmd.sx_last;
      msg_out.overflow    <= cmd.sx_ov;
    end else if (acc && emit) begin
      msg_out.kind        <= e_kind;
      msg_out.status_byte <= e_st;
      msg_out.first_data  <= e_d1;
      msg_out.second_data <= e_d2;
      msg_out.sysex_byte  <= '0;
      msg_out.last        <= 1'b1;
      msg_out.overflow    <= 1'b0;
    end
  end

endmodule

/* hdl/midi_byte_parser_unit.sv */
// midi byte parser: one byte per cycle while the output register is free and no sysex run is being emitted
// channel and realtime results are registered and appear in the cycle after the byte transaction
// a sysex end reads the store once (S_LOAD), then emits its stored bytes at one per cycle while
//   the output register is free; the byte channel stays closed for the whole run of at most MAX_RESULTS bytes
// rst is synchronous, active high: parser state cleared, store left unwritten
`include "assert_macros.svh"

module midi_byte_parser_unit #(
  parameter int SYSEX_DEPTH = mbp_pkg::SYSEX_DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  mbp_in_if.sink    byte_in,
  mbp_out_if.source msg_out
);
  import mbp_pkg::*;

  // command and status between the sequencer and the parser datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: byte intake, then the walk over the sysex store on a sysex end
  mbp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // datapath: running status, data byte collection, sysex store, output register
  mbp_datapath #(
    .SYSEX_DEPTH (SYSEX_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .msg_out (msg_out),
    .cmd     (cmd),
    .status  (status)
  );

  // a byte is never taken while a result is stuck in the output register
  `ASSERT_NEVER(a_no_take_when_blocked, byte_in.ready && msg_out.valid && !msg_out.ready)
  // the byte channel is closed while the store is being walked
  `ASSERT_NEVER(a_no_take_during_run, cmd.emit_sx && cmd.in_en)
  // every non-sysex result is the only result of its byte
  `ASSERT_ALWAYS(a_single_is_last,
    (msg_out.valid && msg_out.kind != KIND_SYSEX) |-> msg_out.last)
  // sysex results carry the sysex start as their status
  `ASSERT_ALWAYS(a_sysex_status,
    (msg_out.valid && msg_out.kind == KIND_SYSEX) |-> (msg_out.status_byte == ST_SYSEX_START))

endmodule

/* bench/midi_msg_checker.sv */
module midi_msg_checker (
  input  logic clk,
  input  logic rst,
  mbp_in_if    byte_in,
  mbp_out_if   msg_out,
  output int   errors,
  output int   pending,
  output int   checked
);
  import mbp_pkg::*;

  localparam int         SX_DEPTH   = SYSEX_DEPTH_DEFAULT;
  localparam logic [7:0] VOICE_LAST = 8'hEF;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [7:0] sysex_byte;
    logic       last;
    logic       overflow;
  } midi_msg_t;

  // parser state as seen from the byte stream
  logic [7:0] run_status;
  logic [6:0] last_ctl;
  logic [7:0] msg_head;
  logic [6:0] held_data;
  int         fill;
  logic [7:0] sx_mem [SX_DEPTH];
  logic       sx_ovf;

  midi_msg_t  awaited_msgs [$];
  int         err_cnt;
  int         ok_cnt;

  function automatic void await_msg(kind_t k, logic [7:0] st, logic [6:0] d1,
                                    logic [6:0] d2, logic [7:0] sx, logic ov);
    midi_msg_t m;
    m = '{kind: k, status_byte: st, first_data: d1, second_data: d2,
          sysex_byte: sx, last: 1'b1, overflow: ov};
    awaited_msgs.push_back(m);
  endfunction

  function automatic void store_sysex(logic [7:0] b);
    if (fill < SX_DEPTH) begin
      sx_mem[fill] = b;
      fill++;
    end else begin
      sx_ovf = 1'b1;
    end
  endfunction

  // works out the messages that one accepted byte releases
  function automatic void parse_midi_byte(logic [7:0] b);
    logic [3:0] hi;
    logic [6:0] d1;
    logic       ov;
    logic       drop;
    int         n;
    midi_msg_t  m;
    hi = run_status[7:4];
    if (b[7]) begin
      if (b <= VOICE_LAST) begin
        msg_head   = b;
        run_status = b;
        fill       = 1;
        sx_ovf     = 1'b0;
      end else if (b >= ST_RT_FIRST && b <= ST_RT_LAST) begin
        await_msg(KIND_REALTIME, b, '0, '0, '0, 1'b0);
      end else if (b == ST_SYSEX_START) begin
        run_status = '0;
        msg_head   = ST_SYSEX_START;
        fill       = 0;
        sx_ovf     = 1'b0;
        store_sysex(b);
      end else if (b == ST_SYSEX_END) begin
        run_status = '0;
        if (msg_head == ST_SYSEX_START) begin
          store_sysex(b);
          n  = fill;
          ov = sx_ovf;
          if (n > MAX_RESULTS) begin
            n  = MAX_RESULTS;
            ov = 1'b1;
          end
          for (int i = 0; i < n; i++) begin
            m = '{kind: KIND_SYSEX, status_byte: ST_SYSEX_START, first_data: '0,
                  second_data: '0, sysex_byte: sx_mem[i], last: (i == n - 1),
                  overflow: ov};
            awaited_msgs.push_back(m);
          end
        end
        msg_head = '0;
        fill     = 0;
        sx_ovf   = 1'b0;
      end else if (b <= ST_COMMON_LAST) begin
        run_status = '0;
        msg_head   = b;
        fill       = 0;
        sx_ovf     = 1'b0;
      end
    end else if (msg_head == ST_SYSEX_START) begin
      store_sysex(b);
    end else if (fill == 1 && run_status[7]) begin
      if (hi == HI_CHANAT || hi == HI_PROGCHG) begin
        await_msg(hi == HI_CHANAT ? KIND_CHANAT : KIND_PROGCHG, run_status,
                  b[6:0], '0, '0, 1'b0);
      end else begin
        held_data = b[6:0];
        fill      = 2;
      end
    end else if (fill == 2 && run_status[7]) begin
      d1   = held_data;
      fill = 1;
      if (hi == HI_NOTEON && b != '0) begin
        await_msg(KIND_NOTEON, run_status, d1, b[6:0], '0, 1'b0);
      end else if (hi == HI_NOTEOFF || hi == HI_NOTEON) begin
        await_msg(KIND_NOTEOFF, run_status, d1, '0, '0, 1'b0);
      end else if (hi == HI_CC) begin
        // fine controller right after its coarse partner is swallowed
        drop     = d1 >= CTL_FINE_LO && d1 <= CTL_FINE_HI &&
                   last_ctl == d1 - CTL_FINE_STEP;
        last_ctl = d1;
        if (!drop) await_msg(KIND_CC, run_status, d1, b[6:0], '0, 1'b0);
      end else if (hi == HI_POLYAT) begin
        await_msg(KIND_POLYAT, run_status, d1, b[6:0], '0, 1'b0);
      end else if (hi == HI_BEND) begin
        await_msg(KIND_BEND, run_status, d1, b[6:0], '0, 1'b0);
      end
    end
  endfunction

  function automatic int field_ok(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 0;
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    midi_msg_t exp_msg;
    int        good;
    if (rst) begin
      run_status = '0;
      last_ctl   = CTL_RESET;
      msg_head   = '0;
      held_data  = '0;
      fill       = 0;
      sx_ovf     = 1'b0;
      awaited_msgs.delete();
      err_cnt    = 0;
      ok_cnt     = 0;
    end else begin
      if (byte_in.valid && byte_in.ready) parse_midi_byte(byte_in.in_byte);
      if (msg_out.valid && msg_out.ready) begin
        if (awaited_msgs.size() == 0) begin
          $error("unexpected result: kind %0d status 0x%0h", msg_out.kind,
                 msg_out.status_byte);
          err_cnt++;
        end else begin
          exp_msg = awaited_msgs.pop_front();
          good = field_ok("kind", exp_msg.kind, msg_out.kind)
               & field_ok("status_byte", exp_msg.status_byte, msg_out.status_byte)
               & field_ok("first_data", exp_msg.first_data, msg_out.first_data)
               & field_ok("second_data", exp_msg.second_data, msg_out.second_data)
               & field_ok("sysex_byte", exp_msg.sysex_byte, msg_out.sysex_byte)
               & field_ok("last", exp_msg.last, msg_out.last)
               & field_ok("overflow", exp_msg.overflow, msg_out.overflow);
          if (!good) err_cnt++;
          ok_cnt++;
        end
      end
    end
    errors  <= err_cnt;
    checked <= ok_cnt;
    pending <= awaited_msgs.size();
  end

endmodule

/* bench/tb.sv */
module tb;
  import mbp_pkg::*;

  // run length guard, far above the slowest legal run
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         PHASE_BYTES = 70;
  localparam logic [7:0] BYTE_MAX    = 8'hFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int idle_pct  = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;   // chance per cycle that the receiver drops ready
  int bytes_sent;
  int noise_bytes;
  int cycle_count = 0;
  int errors;
  int pending;
  int checked;

  mbp_in_if  byte_in ();
  mbp_out_if msg_out ();

  midi_byte_parser_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .msg_out (msg_out)
  );

  // predicts and compares every message on the side
  midi_msg_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .msg_out (msg_out),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  // 12 unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random back-pressure according to the current phase
  always @(posedge clk) begin
    msg_out.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one byte transaction, with optional idle cycles in front
  // valid only drops when the sender really idles, so it never toggles within a step
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      byte_in.valid <= 1'b0;
      @(posedge clk);
    end
    byte_in.valid   <= 1'b1;
    byte_in.in_byte <= b;
    do @(posedge clk); while (!(byte_in.valid && byte_in.ready));
    bytes_sent++;
  endtask

  // data byte, sometimes with a realtime byte slipped in front of it
  task automatic send_data(logic [6:0] d);
    if ($urandom_range(19) == 0) send_byte(8'($urandom_range(ST_RT_FIRST, ST_RT_LAST)));
    send_byte({1'b0, d});
  endtask

  // channel voice message with one to three data sets, the later ones in running status
  task automatic send_voice_message();
    logic [3:0] hi;
    logic [3:0] chan;
    int         reps;
    case ($urandom_range(6))
      0: hi = HI_NOTEOFF;
      1: hi = HI_NOTEON;
      2: hi = HI_POLYAT;
      3: hi = HI_CC;
      4: hi = HI_PROGCHG;
      5: hi = HI_CHANAT;
      default: hi = HI_BEND;
    endcase
    chan = 4'($urandom_range(15));
    reps = $urandom_range(1, 3);
    send_byte({hi, chan});
    repeat (reps) begin
      send_data(7'($urandom_range(127)));
      if (hi != HI_PROGCHG && hi != HI_CHANAT) begin
        // zero velocity turns note on into note off
        send_data(($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(127)));
      end
    end
  endtask

  // coarse controller, then mostly its fine partner which must be dropped
  task automatic send_cc_pair();
    logic [3:0] chan;
    logic [6:0] coarse;
    chan   = 4'($urandom_range(15));
    coarse = 7'($urandom_range(31));
    send_byte({HI_CC, chan});
    send_data(coarse);
    send_data(7'($urandom_range(127)));
    if ($urandom_range(3) == 0) send_byte({HI_CC, chan});
    send_data(($urandom_range(3) != 0) ? coarse + CTL_FINE_STEP : 7'($urandom_range(127)));
    send_data(7'($urandom_range(127)));
  endtask

  // sysex: mostly short, now and then long enough to overflow the store
  task automatic send_sysex();
    int len;
    int pick;
    len  = ($urandom_range(99) < 15) ? $urandom_range(25, 40) : $urandom_range(0, 6);
    pick = $urandom_range(99);
    send_byte(ST_SYSEX_START);
    repeat (len) send_data(7'($urandom_range(127)));
    if (pick < 80) begin
      send_byte(ST_SYSEX_END);
    end else if (pick < 90) begin
      // system common status kills the open sysex
      send_byte(8'($urandom_range(ST_SYSEX_START + 1, ST_COMMON_LAST)));
    end else begin
      // voice status aborts it and starts a channel message
      send_voice_message();
    end
  endtask

  // system common, stray sysex end or undefined bytes, then orphan data
  task automatic send_system_byte();
    int pick;
    pick = $urandom_range(2);
    case (pick)
      0: send_byte(8'($urandom_range(ST_SYSEX_START + 1, ST_COMMON_LAST)));
      1: send_byte(ST_SYSEX_END);
      default: send_byte(8'($urandom_range(ST_RT_LAST + 1, BYTE_MAX)));
    endcase
    repeat ($urandom_range(2)) send_data(7'($urandom_range(127)));
  endtask

  task automatic send_random_message();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_voice_message();
    end else if (pick < 45) begin
      send_cc_pair();
    end else if (pick < 65) begin
      send_sysex();
    end else if (pick < 75) begin
      send_byte(8'($urandom_range(ST_RT_FIRST, ST_RT_LAST)));
    end else if (pick < 85) begin
      send_system_byte();
    end else begin
      // raw noise over the full byte range
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(BYTE_MAX)));
      noise_bytes += n;
    end
  endtask

  task automatic send_directed();
    logic [7:0] seq [$];
    seq = {
      8'h90, 8'h7F, 8'h7F,                  // note on, data at top of range
      8'h80, 8'h40, 8'h7F,                  // note off reports velocity as zero
      8'hB3, 8'h05, 8'h01, 8'h25, 8'h02,    // coarse cc then its fine partner
      8'hA0, 8'h11, 8'h22,                  // poly aftertouch
      8'hE1, 8'h00, 8'h40,                  // pitch bend, zero low data
      8'hD2, 8'h7F,                         // channel aftertouch
      8'hC3, 8'h00,                         // program change
      8'hFD,                                // undefined byte ignored
      8'hF0, 8'h55, 8'hFC, 8'hF7,           // sysex with realtime inside
      8'hF0, 8'hF4, 8'h02,                  // common status kills sysex, orphan data
      8'hF0, 8'h9F, 8'h10, 8'h20, 8'hF7     // voice status inside sysex, stray end
    };
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  initial begin
    int target;
    byte_in.valid   = 1'b0;
    byte_in.in_byte = '0;
    bytes_sent      = 0;
    noise_bytes     = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  <= 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  <= 70;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  <= 0;
          stall_pct <= 70;
        end
        default: begin
          idle_pct  <= 7;
          stall_pct <= 7;
        end
      endcase
      @(posedge clk);
      if (phase == 0) send_directed();
      target = bytes_sent - noise_bytes + PHASE_BYTES;
      while (bytes_sent - noise_bytes < target) send_random_message();
      // sender holds off until every predicted message has drained
      byte_in.valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
    end

    // allow for a late sysex run that nobody predicted
    repeat (150) @(posedge clk);

    $display("covered %0d parser bytes plus %0d noise bytes over four handshake phases",
             bytes_sent - noise_bytes, noise_bytes);
    $display("%0d messages compared, %0d failures", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/mbp_pkg.sv
hdl/mbp_in_if.sv
hdl/mbp_out_if.sv
hdl/mbp_ctrl.sv
hdl/mbp_datapath.sv
hdl/midi_byte_parser_unit.sv
bench/midi_msg_checker.sv
bench/tb.sv
